[hw/rtl/pbmp_pkg.sv]
// ----------------------------------------------------------------------------
// pbmp_pkg: shared types and constants for the majority probability core
// Fixed-point formats, distribution depth and the control word that the
// sequencer hands to every distribution cell.
// ----------------------------------------------------------------------------
`default_nettype none

package pbmp_pkg;

    // largest number of coins held in one set
    localparam int unsigned MAX_COINS = 64;
    // fraction bits of a head probability
    localparam int unsigned PROB_BITS = 16;

    // probability word: Q0.PROB_BITS plus one integer bit for 1.0
    localparam int unsigned PROB_W = PROB_BITS + 1;
    // distribution entry: Q1.31
    localparam int unsigned DIST_W = 32;
    // coin counter, wide enough to hold MAX_COINS itself
    localparam int unsigned COUNT_W = $clog2(MAX_COINS + 1);
    // reported coin count field
    localparam int unsigned SHOWN_W = 7;
    localparam int unsigned SHOWN_MAX = (1 << SHOWN_W) - 1;

    localparam logic [PROB_W-1:0] ONE_PROB = PROB_W'(1) << PROB_BITS;
    localparam logic [DIST_W-1:0] ONE_DIST = DIST_W'(1) << (DIST_W - 1);
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_COINS);

    // control word broadcast to the cell chain
    typedef struct packed {
        logic mul;    // register both products of the update
        logic add;    // sum the products into the entry
        logic shift;  // move each entry one cell toward cell zero
        logic seed;   // load the one-point distribution
    } cell_ctl_t;

endpackage : pbmp_pkg

`default_nettype wire

[hw/rtl/pbmp_cell.sv]
// ----------------------------------------------------------------------------
// pbmp_cell: one entry of the head count distribution
// Holds one Q1.31 probability, forms two truncated products (own entry by q,
// neighbor below by p) and shifts toward cell zero while the set is read out.
// ----------------------------------------------------------------------------
`default_nettype none

module pbmp_cell
    import pbmp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_cell,
    input  wire cell_ctl_t         ctl,
    input  wire logic [PROB_W-1:0] p,
    input  wire logic [PROB_W-1:0] q,
    input  wire logic [DIST_W-1:0] lower_val,
    input  wire logic [DIST_W-1:0] upper_val,
    output logic      [DIST_W-1:0] val
);

    logic [DIST_W-1:0]        val_reg;
    logic [DIST_W-1:0]        val_next;
    logic [DIST_W-1:0]        keep_reg;
    logic [DIST_W-1:0]        move_reg;
    logic [DIST_W+PROB_W-1:0] keep_full;
    logic [DIST_W+PROB_W-1:0] move_full;
    logic [DIST_W:0]          sum;
    logic [DIST_W-1:0]        seed_val;

    // products of the update, truncated back to Q1.31
    assign keep_full = {{PROB_W{1'b0}}, val_reg} * {{DIST_W{1'b0}}, q};
    assign move_full = {{PROB_W{1'b0}}, lower_val} * {{DIST_W{1'b0}}, p};

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            keep_reg <= keep_full[PROB_BITS +: DIST_W];
            move_reg <= move_full[PROB_BITS +: DIST_W];
        end
    end

    // saturating sum of the two products
    assign sum      = {1'b0, keep_reg} + {1'b0, move_reg};
    assign seed_val = head_cell ? ONE_DIST : '0;

    always_comb
    begin
        val_next = val_reg;
        priority if (ctl.seed)
        begin
            val_next = seed_val;
        end
        else if (ctl.shift)
        begin
            val_next = upper_val;
        end
        else if (ctl.add)
        begin
            val_next = (sum > {1'b0, ONE_DIST}) ? ONE_DIST : sum[DIST_W-1:0];
        end
    end

    // entry state, one-point distribution after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= head_cell ? ONE_DIST : '0;
        end
        else
        begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule : pbmp_cell

`default_nettype wire

[hw/rtl/pbmp_ctrl.sv]
// ----------------------------------------------------------------------------
// pbmp_ctrl: transaction sequencer for the majority probability core
// Takes coins, steps the cell chain through multiply and add, drains the
// chain into the majority accumulator and holds the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module pbmp_ctrl
    import pbmp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [PROB_W-1:0]  head_prob,
    input  wire logic               last_coin,
    input  wire logic               coin_valid,
    output logic                    coin_stall,
    output logic [DIST_W-1:0]       majority_prob,
    output logic [SHOWN_W-1:0]      coin_count,
    output logic                    too_many,
    output logic                    result_valid,
    input  wire logic               result_stall,
    input  wire logic [DIST_W-1:0]  drain_val,
    output cell_ctl_t               ctl,
    output logic [PROB_W-1:0]       p,
    output logic [PROB_W-1:0]       q
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [COUNT_W-1:0] coins_reg;
    logic [COUNT_W-1:0] coins_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               last_reg;
    logic               last_next;
    logic [COUNT_W-1:0] idx_reg;
    logic [COUNT_W-1:0] idx_next;
    logic [DIST_W-1:0]  acc_reg;
    logic [DIST_W-1:0]  acc_next;
    logic [PROB_W-1:0]  p_reg;
    logic [PROB_W-1:0]  p_next;
    logic               res_valid_reg;
    logic [DIST_W-1:0]  res_prob_reg;
    logic [SHOWN_W-1:0] res_count_reg;
    logic               res_many_reg;
    logic               coin_take;
    logic               res_free;
    logic               res_load;
    logic [PROB_W-1:0]  p_sat;
    logic [DIST_W:0]    acc_sum;
    logic               in_range;
    logic [SHOWN_W-1:0] shown;

    assign coin_take = coin_valid && (state_reg == ST_IDLE);
    assign coin_stall = (state_reg != ST_IDLE);
    assign res_free  = !res_valid_reg || !result_stall;
    assign res_load  = (state_reg == ST_DONE) && res_free;

    // probability above one is clipped to one
    assign p_sat = (head_prob > ONE_PROB) ? ONE_PROB : head_prob;

    // majority window: floor(n/2) < index <= n
    assign in_range = (idx_reg > (coins_reg >> 1)) && (idx_reg <= coins_reg);
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, drain_val};

    assign shown = (32'(coins_reg) > SHOWN_MAX) ? SHOWN_W'(SHOWN_MAX)
                                                : SHOWN_W'(coins_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        coins_next = coins_reg;
        ovf_next   = ovf_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (coin_take)
                begin
                    last_next = last_coin;
                    idx_next  = '0;
                    acc_next  = '0;
                    if (coins_reg < MAX_COUNT)
                    begin
                        p_next     = p_sat;
                        coins_next = coins_reg + COUNT_W'(1);
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        if (last_coin)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                ctl.add    = 1'b1;
                state_next = last_reg ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN:
            begin
                ctl.shift = 1'b1;
                if (in_range)
                begin
                    acc_next = (acc_sum > {1'b0, ONE_DIST}) ? ONE_DIST
                                                            : acc_sum[DIST_W-1:0];
                end
                idx_next = idx_reg + COUNT_W'(1);
                if (idx_reg == MAX_COUNT)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    ctl.seed   = 1'b1;
                    coins_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            coins_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            coins_reg <= coins_next;
            ovf_reg   <= ovf_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        idx_reg  <= idx_next;
        acc_reg  <= acc_next;
        p_reg    <= p_next;
        if (res_load)
        begin
            res_prob_reg  <= acc_reg;
            res_count_reg <= shown;
            res_many_reg  <= ovf_reg;
        end
    end

    assign p             = p_reg;
    assign q             = ONE_PROB - p_reg;
    assign result_valid  = res_valid_reg;
    assign majority_prob = res_prob_reg;
    assign coin_count    = res_count_reg;
    assign too_many      = res_many_reg;

endmodule : pbmp_ctrl

`default_nettype wire

[hw/rtl/poisson_binomial_majority_prob_core.sv]
// ----------------------------------------------------------------------------
// poisson_binomial_majority_prob_core: strict head majority probability
// Accumulates the head count distribution of independent coins in a chain of
// multiply-add cells and reports P(heads > floor(n/2)) on the last coin.
// ----------------------------------------------------------------------------
// A coin transaction carries its head probability in Q1.16 (values above 1.0
// are clipped) and a last flag. Each counted coin steps through acceptance,
// then a state in which every cell registers its two products and one in
// which every cell adds them; all MAX_COINS+1 cells work in parallel. A coin
// beyond MAX_COINS only sets the overflow flag. A last coin additionally
// drains the chain through cell zero into the majority accumulator, then
// posts the result transaction and reseeds the chain. The result sits in an
// output register; the core holds only in its final state while an earlier
// result is still stalled.
`default_nettype none

module poisson_binomial_majority_prob_core
    import pbmp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [PROB_W-1:0]  head_prob,
    input  wire logic               last_coin,
    input  wire logic               coin_valid,
    output logic                    coin_stall,
    output logic [DIST_W-1:0]       majority_prob,
    output logic [SHOWN_W-1:0]      coin_count,
    output logic                    too_many,
    output logic                    result_valid,
    input  wire logic               result_stall
);

    cell_ctl_t         ctl;
    logic [PROB_W-1:0] p;
    logic [PROB_W-1:0] q;
    logic [DIST_W-1:0] dist_val [0:MAX_COINS];

    // sequencer and result register
    pbmp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_prob     (head_prob),
        .last_coin     (last_coin),
        .coin_valid    (coin_valid),
        .coin_stall    (coin_stall),
        .majority_prob (majority_prob),
        .coin_count    (coin_count),
        .too_many      (too_many),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .drain_val     (dist_val[0]),
        .ctl           (ctl),
        .p             (p),
        .q             (q)
    );

    // row of distribution cells, entry k holds P(heads == k)
    for (genvar k = 0; k <= MAX_COINS; k++)
    begin : g_cell
        logic [DIST_W-1:0] lower_val;
        logic [DIST_W-1:0] upper_val;

        if (k == 0)
        begin : g_bottom
            assign lower_val = '0;
        end
        else
        begin : g_mid_lo
            assign lower_val = dist_val[k-1];
        end

        if (k == MAX_COINS)
        begin : g_top
            assign upper_val = '0;
        end
        else
        begin : g_mid_hi
            assign upper_val = dist_val[k+1];
        end

        pbmp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .head_cell (k == 0),
            .ctl       (ctl),
            .p         (p),
            .q         (q),
            .lower_val (lower_val),
            .upper_val (upper_val),
            .val       (dist_val[k])
        );
    end

endmodule : poisson_binomial_majority_prob_core

`default_nettype wire
